// File: rtl/stk_pkg.sv
package stk_pkg;

   // Queue between the command parser and the response sequencer.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One token expands into at most this many results.
   localparam int MAX_RESULTS = 5;
   localparam int STEP_W = $clog2(MAX_RESULTS);

   // Configuration port.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLASH_BASE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_EEPROM_BASE   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SW_MAJOR      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SW_MINOR      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HW_VERSION    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIGNATURE_MID = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIGNATURE_LOW = 3'd6;

   localparam logic [15:0] FLASH_BASE_RESET  = 16'h8000;
   localparam logic [15:0] EEPROM_BASE_RESET = 16'h1400;
   localparam logic [7:0]  SW_MAJOR_RESET    = 8'd3;
   localparam logic [7:0]  SW_MINOR_RESET    = 8'd7;
   localparam logic [7:0]  HW_VERSION_RESET  = 8'd0;
   localparam logic [7:0]  SIGNATURE_RESET   = 8'd0;

   // Protocol bytes.
   localparam logic [7:0] CMD_GET_PARAM      = 8'h41;
   localparam logic [7:0] CMD_SET_DEVICE     = 8'h42;
   localparam logic [7:0] CMD_SET_DEVICE_EXT = 8'h45;
   localparam logic [7:0] CMD_LOAD_ADDRESS   = 8'h55;
   localparam logic [7:0] CMD_PROG_PAGE      = 8'h64;
   localparam logic [7:0] CMD_READ_PAGE      = 8'h74;
   localparam logic [7:0] CMD_READ_SIGN      = 8'h75;
   localparam logic [7:0] BYTE_EOP           = 8'h20;
   localparam logic [7:0] BYTE_INSYNC        = 8'h14;
   localparam logic [7:0] BYTE_OK            = 8'h10;
   localparam logic [7:0] BYTE_SIG_HIGH      = 8'h1E;
   localparam logic [7:0] BYTE_MEM_FLASH     = 8'h46;
   localparam logic [7:0] PARAM_SW_MAJOR     = 8'h81;
   localparam logic [7:0] PARAM_SW_MINOR     = 8'h82;
   localparam logic [4:0] DROP_SET_DEVICE     = 5'd20;
   localparam logic [4:0] DROP_SET_DEVICE_EXT = 5'd5;

   typedef enum logic [2:0] {
      KIND_TX     = 3'd0,
      KIND_WRITE  = 3'd1,
      KIND_READ   = 3'd2,
      KIND_COMMIT = 3'd3,
      KIND_RESET  = 3'd4
   } kind_type;

   typedef enum logic [3:0] {
      ACT_WRITE        = 4'd0,
      ACT_WRITE_COMMIT = 4'd1,
      ACT_PLAIN        = 4'd2,
      ACT_PARAM        = 4'd3,
      ACT_SIGN         = 4'd4,
      ACT_READ         = 4'd5,
      ACT_RDATA_NEXT   = 4'd6,
      ACT_RDATA_DONE   = 4'd7,
      ACT_RESET        = 4'd8
   } action_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  data;
      logic [15:0] address;
   } token_type;

   typedef struct packed {
      logic [15:0] flash_base;
      logic [15:0] eeprom_base;
      logic [7:0]  sw_major;
      logic [7:0]  sw_minor;
      logic [7:0]  hw_version;
      logic [7:0]  signature_mid;
      logic [7:0]  signature_low;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [15:0] address;
      logic        last;
   } result_type;

endpackage

// File: rtl/stk_front.sv
module stk_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               operation,
   input  logic [7:0]         data_byte,
   input  stk_pkg::cfg_type   cfg,
   output logic               tok_valid,
   output stk_pkg::token_type tok
);

   typedef enum logic [16:0] {
      PH_IDLE      = 17'b00000000000000001,
      PH_GP_ID     = 17'b00000000000000010,
      PH_DROP      = 17'b00000000000000100,
      PH_LA_LO     = 17'b00000000000001000,
      PH_LA_HI     = 17'b00000000000010000,
      PH_PP_LHI    = 17'b00000000000100000,
      PH_PP_LLO    = 17'b00000000001000000,
      PH_PP_MEM    = 17'b00000000010000000,
      PH_PP_DATA   = 17'b00000000100000000,
      PH_RP_LHI    = 17'b00000001000000000,
      PH_RP_LLO    = 17'b00000010000000000,
      PH_RP_MEM    = 17'b00000100000000000,
      PH_RD_WAIT   = 17'b00001000000000000,
      PH_EOP_PLAIN = 17'b00010000000000000,
      PH_EOP_PARAM = 17'b00100000000000000,
      PH_EOP_SIGN  = 17'b01000000000000000,
      PH_EOP_READ  = 17'b10000000000000000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] cursor_ff, cursor_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [7:0]  held_ff, held_in;
   logic [4:0]  drop_ff, drop_in;

   logic [15:0] cursor_inc;
   logic [15:0] remain_dec;
   logic [15:0] base;
   logic [7:0]  param_value;
   logic [4:0]  drop_dec;
   logic        eop_phase;

   assign cursor_inc = cursor_ff + 16'd1;
   assign remain_dec = remaining_ff - 16'd1;
   assign drop_dec   = drop_ff - 5'd1;
   assign base = (data_byte == stk_pkg::BYTE_MEM_FLASH) ? cfg.flash_base : cfg.eeprom_base;
   assign param_value = (held_ff == stk_pkg::PARAM_SW_MINOR) ? cfg.sw_minor :
                        (held_ff == stk_pkg::PARAM_SW_MAJOR) ? cfg.sw_major : cfg.hw_version;
   assign eop_phase = (phase_ff == PH_EOP_PLAIN) || (phase_ff == PH_EOP_PARAM) ||
                      (phase_ff == PH_EOP_SIGN) || (phase_ff == PH_EOP_READ);

   always_comb begin
      phase_in     = phase_ff;
      cursor_in    = cursor_ff;
      remaining_in = remaining_ff;
      held_in      = held_ff;
      drop_in      = drop_ff;
      tok_valid    = 1'b0;
      tok.action   = stk_pkg::ACT_PLAIN;
      tok.data     = data_byte;
      tok.address  = cursor_ff;
      if (accept) begin
         if (operation) begin
            // Read data counts only while a page read waits for it.
            if (phase_ff == PH_RD_WAIT) begin
               cursor_in    = cursor_inc;
               remaining_in = remain_dec;
               tok_valid    = 1'b1;
               tok.address  = cursor_inc;
               if (remain_dec == 16'd0) begin
                  tok.action = stk_pkg::ACT_RDATA_DONE;
                  phase_in   = PH_IDLE;
               end else begin
                  tok.action = stk_pkg::ACT_RDATA_NEXT;
               end
            end
         end else if (eop_phase && (data_byte != stk_pkg::BYTE_EOP)) begin
            phase_in     = PH_IDLE;
            cursor_in    = 16'd0;
            remaining_in = 16'd0;
            held_in      = 8'd0;
            drop_in      = 5'd0;
            tok_valid    = 1'b1;
            tok.action   = stk_pkg::ACT_RESET;
         end else begin
            unique case (phase_ff)
               PH_IDLE: begin
                  unique case (data_byte)
                     stk_pkg::CMD_GET_PARAM: phase_in = PH_GP_ID;
                     stk_pkg::CMD_SET_DEVICE: begin
                        drop_in  = stk_pkg::DROP_SET_DEVICE;
                        phase_in = PH_DROP;
                     end
                     stk_pkg::CMD_SET_DEVICE_EXT: begin
                        drop_in  = stk_pkg::DROP_SET_DEVICE_EXT;
                        phase_in = PH_DROP;
                     end
                     stk_pkg::CMD_LOAD_ADDRESS: phase_in = PH_LA_LO;
                     stk_pkg::CMD_PROG_PAGE:    phase_in = PH_PP_LHI;
                     stk_pkg::CMD_READ_PAGE:    phase_in = PH_RP_LHI;
                     stk_pkg::CMD_READ_SIGN:    phase_in = PH_EOP_SIGN;
                     default:                   phase_in = PH_EOP_PLAIN;
                  endcase
               end
               PH_GP_ID: begin
                  held_in  = data_byte;
                  phase_in = PH_EOP_PARAM;
               end
               PH_DROP: begin
                  drop_in = drop_dec;
                  if (drop_dec == 5'd0) begin
                     phase_in = PH_EOP_PLAIN;
                  end
               end
               PH_LA_LO: begin
                  cursor_in = {cursor_ff[15:8], data_byte};
                  phase_in  = PH_LA_HI;
               end
               PH_LA_HI: begin
                  cursor_in = {data_byte, cursor_ff[7:0]};
                  phase_in  = PH_EOP_PLAIN;
               end
               PH_PP_LHI: begin
                  remaining_in = {data_byte, remaining_ff[7:0]};
                  phase_in     = PH_PP_LLO;
               end
               PH_RP_LHI: begin
                  remaining_in = {data_byte, remaining_ff[7:0]};
                  phase_in     = PH_RP_LLO;
               end
               PH_PP_LLO: begin
                  remaining_in = {remaining_ff[15:8], data_byte};
                  phase_in     = PH_PP_MEM;
               end
               PH_RP_LLO: begin
                  remaining_in = {remaining_ff[15:8], data_byte};
                  phase_in     = PH_RP_MEM;
               end
               PH_PP_MEM: begin
                  cursor_in = cursor_ff + base;
                  phase_in  = PH_PP_DATA;
               end
               PH_RP_MEM: begin
                  cursor_in = cursor_ff + base;
                  phase_in  = PH_EOP_READ;
               end
               PH_PP_DATA: begin
                  // A length of zero wraps, so the page then holds 65536 bytes.
                  cursor_in    = cursor_inc;
                  remaining_in = remain_dec;
                  tok_valid    = 1'b1;
                  if (remain_dec == 16'd0) begin
                     tok.action = stk_pkg::ACT_WRITE_COMMIT;
                     phase_in   = PH_EOP_PLAIN;
                  end else begin
                     tok.action = stk_pkg::ACT_WRITE;
                  end
               end
               PH_RD_WAIT: begin
               end
               PH_EOP_PLAIN: begin
                  tok_valid  = 1'b1;
                  tok.action = stk_pkg::ACT_PLAIN;
                  phase_in   = PH_IDLE;
               end
               PH_EOP_PARAM: begin
                  tok_valid  = 1'b1;
                  tok.action = stk_pkg::ACT_PARAM;
                  tok.data   = param_value;
                  phase_in   = PH_IDLE;
               end
               PH_EOP_SIGN: begin
                  tok_valid  = 1'b1;
                  tok.action = stk_pkg::ACT_SIGN;
                  phase_in   = PH_IDLE;
               end
               PH_EOP_READ: begin
                  tok_valid  = 1'b1;
                  tok.action = stk_pkg::ACT_READ;
                  phase_in   = PH_RD_WAIT;
               end
               default: begin
                  phase_in     = PH_IDLE;
                  cursor_in    = 16'd0;
                  remaining_in = 16'd0;
                  held_in      = 8'd0;
                  drop_in      = 5'd0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cursor_ff    <= 16'd0;
         remaining_ff <= 16'd0;
         held_ff      <= 8'd0;
         drop_ff      <= 5'd0;
      end else begin
         phase_ff     <= phase_in;
         cursor_ff    <= cursor_in;
         remaining_ff <= remaining_in;
         held_ff      <= held_in;
         drop_ff      <= drop_in;
      end
   end

endmodule

// File: rtl/stk_queue.sv
module stk_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  stk_pkg::token_type push_data,
   input  logic               pop,
   output logic               empty,
   output logic               full,
   output stk_pkg::token_type head
);

   localparam logic [stk_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      stk_pkg::QUEUE_PTR_W'(stk_pkg::QUEUE_DEPTH - 1);
   localparam logic [stk_pkg::QUEUE_CNT_W-1:0] DEPTH_COUNT =
      stk_pkg::QUEUE_CNT_W'(stk_pkg::QUEUE_DEPTH);

   stk_pkg::token_type                entry_ff [stk_pkg::QUEUE_DEPTH];
   logic [stk_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [stk_pkg::QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [stk_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                              do_push;
   logic                              do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == DEPTH_COUNT);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_COUNT)
      else $error("token queue count exceeds its depth");
`endif

endmodule

// File: rtl/stk_back.sv
module stk_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_empty,
   input  stk_pkg::token_type head,
   input  stk_pkg::cfg_type   cfg,
   input  logic               rsp_pop,
   output logic               q_pop,
   output logic               rsp_empty,
   output stk_pkg::result_type rsp
);

   logic [stk_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       valid_ff, valid_in;
   stk_pkg::result_type        rsp_ff, rsp_in;
   stk_pkg::result_type        res;
   logic                       load;

   // Expand the head token into its result for the current step.
   always_comb begin
      res.kind    = stk_pkg::KIND_TX;
      res.data    = 8'h00;
      res.address = 16'h0000;
      res.last    = 1'b1;
      case (head.action)
         stk_pkg::ACT_WRITE: begin
            res.kind    = stk_pkg::KIND_WRITE;
            res.data    = head.data;
            res.address = head.address;
         end
         stk_pkg::ACT_WRITE_COMMIT: begin
            if (step_ff == '0) begin
               res.kind    = stk_pkg::KIND_WRITE;
               res.data    = head.data;
               res.address = head.address;
               res.last    = 1'b0;
            end else begin
               res.kind = stk_pkg::KIND_COMMIT;
            end
         end
         stk_pkg::ACT_PLAIN: begin
            if (step_ff == '0) begin
               res.data = stk_pkg::BYTE_INSYNC;
               res.last = 1'b0;
            end else begin
               res.data = stk_pkg::BYTE_OK;
            end
         end
         stk_pkg::ACT_PARAM: begin
            res.last = 1'b0;
            case (step_ff)
               3'd0: res.data = stk_pkg::BYTE_INSYNC;
               3'd1: res.data = head.data;
               default: begin
                  res.data = stk_pkg::BYTE_OK;
                  res.last = 1'b1;
               end
            endcase
         end
         stk_pkg::ACT_SIGN: begin
            res.last = 1'b0;
            case (step_ff)
               3'd0: res.data = stk_pkg::BYTE_INSYNC;
               3'd1: res.data = stk_pkg::BYTE_SIG_HIGH;
               3'd2: res.data = cfg.signature_mid;
               3'd3: res.data = cfg.signature_low;
               default: begin
                  res.data = stk_pkg::BYTE_OK;
                  res.last = 1'b1;
               end
            endcase
         end
         stk_pkg::ACT_READ: begin
            if (step_ff == '0) begin
               res.data = stk_pkg::BYTE_INSYNC;
               res.last = 1'b0;
            end else begin
               res.kind    = stk_pkg::KIND_READ;
               res.address = head.address;
            end
         end
         stk_pkg::ACT_RDATA_NEXT: begin
            if (step_ff == '0) begin
               res.data = head.data;
               res.last = 1'b0;
            end else begin
               res.kind    = stk_pkg::KIND_READ;
               res.address = head.address;
            end
         end
         stk_pkg::ACT_RDATA_DONE: begin
            if (step_ff == '0) begin
               res.data = head.data;
               res.last = 1'b0;
            end else begin
               res.data = stk_pkg::BYTE_OK;
            end
         end
         stk_pkg::ACT_RESET: begin
            res.kind = stk_pkg::KIND_RESET;
         end
         default: begin
         end
      endcase
   end

   // The output register takes a new result whenever it is free or being drained.
   assign load      = !valid_ff || rsp_pop;
   assign q_pop     = load && !q_empty && res.last;
   assign rsp_empty = !valid_ff;
   assign rsp       = rsp_ff;

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      if (load) begin
         valid_in = !q_empty;
         if (!q_empty) begin
            rsp_in  = res;
            step_in = res.last ? '0 : step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

`ifndef SYNTHESIS
   a_step_has_head: assert property (@(posedge clock) disable iff (reset)
      (step_ff != '0) |-> !q_empty)
      else $error("response step advanced without a token at the queue head");

   a_reset_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && (rsp_ff.kind == stk_pkg::KIND_RESET)) |-> rsp_ff.last)
      else $error("reset result not marked as last");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !valid_ff)
      else $error("response register holds a result right after reset");
`endif

endmodule

// File: rtl/stk500v1_command_engine.sv
// Channel   Ports                                   Direction  Transaction
// request   req_push/req_full, req_operation,       in         push && !full
//           req_data_byte
// response  rsp_pop/rsp_empty, rsp_kind,            out        pop && !empty
//           rsp_tx_or_write_byte, rsp_mem_address,
//           rsp_last
// csr       csr_write_enable, csr_index,            in         write_enable
//           csr_write_data
//
// The parser takes one byte a cycle while the four-entry token queue has room.
// The response sequencer emits one result a cycle while rsp_pop drains it, so a
// command answer is one to five results; queue drain sets the sustained input rate.
// Reset is synchronous and clears the parser, the queue and the output register;
// the configuration registers return to their defaults.
// A stalled rsp_pop holds the output; the queue then fills and req_full rises.
module stk500v1_command_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic                            req_operation,
   input  logic [7:0]                      req_data_byte,
   input  logic                            rsp_pop,
   output logic                            rsp_empty,
   output logic [2:0]                      rsp_kind,
   output logic [7:0]                      rsp_tx_or_write_byte,
   output logic [15:0]                     rsp_mem_address,
   output logic                            rsp_last,
   input  logic                            csr_write_enable,
   input  logic [stk_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [stk_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   stk_pkg::cfg_type    cfg_ff, cfg_in;
   logic                accept;
   logic                tok_valid;
   stk_pkg::token_type  tok;
   logic                q_empty;
   logic                q_full;
   logic                q_pop;
   stk_pkg::token_type  head;
   stk_pkg::result_type rsp;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            stk_pkg::CSR_FLASH_BASE:    cfg_in.flash_base    = csr_write_data;
            stk_pkg::CSR_EEPROM_BASE:   cfg_in.eeprom_base   = csr_write_data;
            stk_pkg::CSR_SW_MAJOR:      cfg_in.sw_major      = csr_write_data[7:0];
            stk_pkg::CSR_SW_MINOR:      cfg_in.sw_minor      = csr_write_data[7:0];
            stk_pkg::CSR_HW_VERSION:    cfg_in.hw_version    = csr_write_data[7:0];
            stk_pkg::CSR_SIGNATURE_MID: cfg_in.signature_mid = csr_write_data[7:0];
            stk_pkg::CSR_SIGNATURE_LOW: cfg_in.signature_low = csr_write_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.flash_base    <= stk_pkg::FLASH_BASE_RESET;
         cfg_ff.eeprom_base   <= stk_pkg::EEPROM_BASE_RESET;
         cfg_ff.sw_major      <= stk_pkg::SW_MAJOR_RESET;
         cfg_ff.sw_minor      <= stk_pkg::SW_MINOR_RESET;
         cfg_ff.hw_version    <= stk_pkg::HW_VERSION_RESET;
         cfg_ff.signature_mid <= stk_pkg::SIGNATURE_RESET;
         cfg_ff.signature_low <= stk_pkg::SIGNATURE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   stk_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .operation (req_operation),
      .data_byte (req_data_byte),
      .cfg       (cfg_ff),
      .tok_valid (tok_valid),
      .tok       (tok)
   );

   stk_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (tok_valid),
      .push_data (tok),
      .pop       (q_pop),
      .empty     (q_empty),
      .full      (q_full),
      .head      (head)
   );

   stk_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .head      (head),
      .cfg       (cfg_ff),
      .rsp_pop   (rsp_pop),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp       (rsp)
   );

   assign rsp_kind             = rsp.kind;
   assign rsp_tx_or_write_byte = rsp.data;
   assign rsp_mem_address      = rsp.address;
   assign rsp_last             = rsp.last;

endmodule
